>>> hdl/pdq_pkg.sv
package pdq_pkg;

    localparam int DATA_WIDTH   = 24;
    localparam int CORDIC_STEPS = 30;
    localparam int CW           = 32;
    localparam int ZW           = 32;

    localparam logic [30:0] SQRT3_Q30    = 31'd1859775394;
    localparam logic [31:0] INV_GAIN_Q30 = 32'd652032874;
    localparam logic [31:0] DIV3_MUL     = 32'hAAAAAAAB;
    localparam int          DIV3_SHIFT   = 33;
    localparam logic [63:0] ROUND_Q30    = 64'd536870912;

    typedef enum logic
    {
        OP_ABC_TO_DQ = 1'b0,
        OP_DQ_TO_ABC = 1'b1
    } op_t;

    // arctangent of 2^-i in units of 2^-32 turn
    function automatic logic [29:0] atan_turn(input logic [4:0] idx);
        case (idx)
            5'd0:    atan_turn = 30'h20000000;
            5'd1:    atan_turn = 30'h12E4051E;
            5'd2:    atan_turn = 30'h09FB385B;
            5'd3:    atan_turn = 30'h051111D4;
            5'd4:    atan_turn = 30'h028B0D43;
            5'd5:    atan_turn = 30'h0145D7E1;
            5'd6:    atan_turn = 30'h00A2F61E;
            5'd7:    atan_turn = 30'h00517C55;
            5'd8:    atan_turn = 30'h0028BE53;
            5'd9:    atan_turn = 30'h00145F2F;
            5'd10:   atan_turn = 30'h000A2F98;
            5'd11:   atan_turn = 30'h000517CC;
            5'd12:   atan_turn = 30'h00028BE6;
            5'd13:   atan_turn = 30'h000145F3;
            5'd14:   atan_turn = 30'h0000A2FA;
            5'd15:   atan_turn = 30'h0000517D;
            5'd16:   atan_turn = 30'h000028BE;
            5'd17:   atan_turn = 30'h0000145F;
            5'd18:   atan_turn = 30'h00000A30;
            5'd19:   atan_turn = 30'h00000518;
            5'd20:   atan_turn = 30'h0000028C;
            5'd21:   atan_turn = 30'h00000146;
            5'd22:   atan_turn = 30'h000000A3;
            5'd23:   atan_turn = 30'h00000051;
            5'd24:   atan_turn = 30'h00000029;
            5'd25:   atan_turn = 30'h00000014;
            5'd26:   atan_turn = 30'h0000000A;
            5'd27:   atan_turn = 30'h00000005;
            5'd28:   atan_turn = 30'h00000003;
            5'd29:   atan_turn = 30'h00000001;
            default: atan_turn = 30'h00000000;
        endcase
    endfunction

    // magnitude times q30 factor, rounded half away from zero, sign applied
    function automatic logic signed [63:0] rnd_q30(input logic [63:0] p, input logic neg);
        logic [63:0] m;
        m = (p + ROUND_Q30) >> 30;
        rnd_q30 = neg ? -$signed(m) : $signed(m);
    endfunction

    function automatic logic [DATA_WIDTH-1:0] sat_data(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = (64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (v > hi)
        begin
            sat_data = hi[DATA_WIDTH-1:0];
        end
        else if (v < lo)
        begin
            sat_data = lo[DATA_WIDTH-1:0];
        end
        else
        begin
            sat_data = v[DATA_WIDTH-1:0];
        end
    endfunction

endpackage

>>> hdl/phasor_dq_abc_transform.sv
// Positive-sequence Park transform on three-phase complex phasors, fully pipelined.
// One request is taken every clock while the skid entry of the output buffer is
// empty; the 30-stage CORDIC that makes cos and sin of the angle sits behind seven
// stages that form the positive sequence and ahead of nine
// stages of rotation, sqrt3 scaling and saturation. s_tuser selects the direction
// (0 abc to dq, 1 dq to abc); fields the direction does not use are ignored and
// the result fields it does not produce read zero. Data is signed with 12 fraction
// bits; the angle is an unsigned fraction of a turn. A two-entry output buffer
// lets the pipeline keep taking requests while a result waits.
module phasor_dq_abc_transform #(
    parameter int ANGLE_WIDTH = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // angle, phase_a_re, phase_a_im, phase_b_re, phase_b_im, phase_c_re, phase_c_im,
    // direct_in, quadrature_in
    input  logic [((ANGLE_WIDTH + 8 * pdq_pkg::DATA_WIDTH + 7) / 8) * 8 - 1:0] s_tdata,
    // opcode
    input  logic [0:0]            s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // direct_out, quadrature_out, out_a_re, out_a_im, out_b_re, out_b_im,
    // out_c_re, out_c_im
    output logic [8 * pdq_pkg::DATA_WIDTH - 1:0] m_tdata
);

    localparam int D   = pdq_pkg::DATA_WIDTH;
    localparam int AW  = ANGLE_WIDTH;
    localparam int N   = pdq_pkg::CORDIC_STEPS;
    localparam int CW  = pdq_pkg::CW;
    localparam int ZW  = pdq_pkg::ZW;
    localparam int NS  = 7 + N + 9;

    localparam int UW  = D + 2;
    localparam int TM  = D + 1;
    localparam int P2W = TM + 31;
    localparam int MW  = D + 4;
    localparam int NW  = D + 4;
    localparam int WW  = D + 3;
    localparam int P6W = WW + 32;
    localparam int XW  = D + 2;
    localparam int RPW = XW + CW;
    localparam int PW  = D + 6;
    localparam int EW  = D + 7;
    localparam int E6W = EW + 31;
    localparam int RW  = D + 10;
    localparam int SW  = D + 11;

    logic en;
    logic [NS-1:0] vld_reg;

    logic out_valid_reg;
    logic skid_valid_reg;
    logic [8*D-1:0] out_data_reg;
    logic [8*D-1:0] skid_data_reg;

    assign en       = !skid_valid_reg;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[NS-2:0], s_tvalid};
        end
    end

    // input field unpacking
    logic signed [D-1:0] a_re, a_im, b_re, b_im, c_re, c_im, d_in, q_in;
    logic signed [D:0]   t_re, t_im;

    assign a_re = $signed(s_tdata[AW +: D]);
    assign a_im = $signed(s_tdata[AW + D +: D]);
    assign b_re = $signed(s_tdata[AW + 2*D +: D]);
    assign b_im = $signed(s_tdata[AW + 3*D +: D]);
    assign c_re = $signed(s_tdata[AW + 4*D +: D]);
    assign c_im = $signed(s_tdata[AW + 5*D +: D]);
    assign d_in = $signed(s_tdata[AW + 6*D +: D]);
    assign q_in = $signed(s_tdata[AW + 7*D +: D]);
    assign t_re = (D+1)'(c_im) - (D+1)'(b_im);
    assign t_im = (D+1)'(b_re) - (D+1)'(c_re);

    // f1: differences for the positive sequence
    pdq_pkg::op_t        f1_op_reg;
    logic [AW-1:0]       f1_ang_reg;
    logic signed [UW-1:0] f1_u_re_reg, f1_u_im_reg;
    logic [TM-1:0]       f1_tm_re_reg, f1_tm_im_reg;
    logic                f1_tn_re_reg, f1_tn_im_reg;
    logic signed [D-1:0] f1_d_reg, f1_q_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f1_op_reg    <= pdq_pkg::op_t'(s_tuser[0]);
            f1_ang_reg   <= s_tdata[AW-1:0];
            f1_u_re_reg  <= (UW'(a_re) <<< 1) - UW'(b_re) - UW'(c_re);
            f1_u_im_reg  <= (UW'(a_im) <<< 1) - UW'(b_im) - UW'(c_im);
            f1_tm_re_reg <= t_re[D] ? TM'(-t_re) : TM'(t_re);
            f1_tm_im_reg <= t_im[D] ? TM'(-t_im) : TM'(t_im);
            f1_tn_re_reg <= t_re[D];
            f1_tn_im_reg <= t_im[D];
            f1_d_reg     <= d_in;
            f1_q_reg     <= q_in;
        end
    end

    // f2: sqrt3 products
    pdq_pkg::op_t        f2_op_reg;
    logic [AW-1:0]       f2_ang_reg;
    logic signed [UW-1:0] f2_u_re_reg, f2_u_im_reg;
    logic [P2W-1:0]      f2_p_re_reg, f2_p_im_reg;
    logic                f2_tn_re_reg, f2_tn_im_reg;
    logic signed [D-1:0] f2_d_reg, f2_q_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f2_op_reg    <= f1_op_reg;
            f2_ang_reg   <= f1_ang_reg;
            f2_u_re_reg  <= f1_u_re_reg;
            f2_u_im_reg  <= f1_u_im_reg;
            f2_p_re_reg  <= P2W'(f1_tm_re_reg) * P2W'(pdq_pkg::SQRT3_Q30);
            f2_p_im_reg  <= P2W'(f1_tm_im_reg) * P2W'(pdq_pkg::SQRT3_Q30);
            f2_tn_re_reg <= f1_tn_re_reg;
            f2_tn_im_reg <= f1_tn_im_reg;
            f2_d_reg     <= f1_d_reg;
            f2_q_reg     <= f1_q_reg;
        end
    end

    // f3: round the sqrt3 term
    pdq_pkg::op_t        f3_op_reg;
    logic [AW-1:0]       f3_ang_reg;
    logic signed [UW-1:0] f3_u_re_reg, f3_u_im_reg;
    logic signed [MW-1:0] f3_m_re_reg, f3_m_im_reg;
    logic signed [D-1:0] f3_d_reg, f3_q_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f3_op_reg   <= f2_op_reg;
            f3_ang_reg  <= f2_ang_reg;
            f3_u_re_reg <= f2_u_re_reg;
            f3_u_im_reg <= f2_u_im_reg;
            f3_m_re_reg <= MW'(pdq_pkg::rnd_q30(64'(f2_p_re_reg), f2_tn_re_reg));
            f3_m_im_reg <= MW'(pdq_pkg::rnd_q30(64'(f2_p_im_reg), f2_tn_im_reg));
            f3_d_reg    <= f2_d_reg;
            f3_q_reg    <= f2_q_reg;
        end
    end

    // f4: six times the positive sequence
    pdq_pkg::op_t        f4_op_reg;
    logic [AW-1:0]       f4_ang_reg;
    logic signed [NW-1:0] f4_n_re_reg, f4_n_im_reg;
    logic signed [D-1:0] f4_d_reg, f4_q_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f4_op_reg   <= f3_op_reg;
            f4_ang_reg  <= f3_ang_reg;
            f4_n_re_reg <= NW'(f3_u_re_reg) + NW'(f3_m_re_reg);
            f4_n_im_reg <= NW'(f3_u_im_reg) + NW'(f3_m_im_reg);
            f4_d_reg    <= f3_d_reg;
            f4_q_reg    <= f3_q_reg;
        end
    end

    // f5: magnitude plus half of six, halved
    logic [NW-1:0] f4_nm_re, f4_nm_im;
    logic [NW-1:0] f4_v_re, f4_v_im;

    assign f4_nm_re = f4_n_re_reg[NW-1] ? NW'(-f4_n_re_reg) : NW'(f4_n_re_reg);
    assign f4_nm_im = f4_n_im_reg[NW-1] ? NW'(-f4_n_im_reg) : NW'(f4_n_im_reg);
    assign f4_v_re  = f4_nm_re + NW'(3);
    assign f4_v_im  = f4_nm_im + NW'(3);

    pdq_pkg::op_t        f5_op_reg;
    logic [AW-1:0]       f5_ang_reg;
    logic [WW-1:0]       f5_w_re_reg, f5_w_im_reg;
    logic                f5_nn_re_reg, f5_nn_im_reg;
    logic signed [D-1:0] f5_d_reg, f5_q_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f5_op_reg    <= f4_op_reg;
            f5_ang_reg   <= f4_ang_reg;
            f5_w_re_reg  <= f4_v_re[NW-1:1];
            f5_w_im_reg  <= f4_v_im[NW-1:1];
            f5_nn_re_reg <= f4_n_re_reg[NW-1];
            f5_nn_im_reg <= f4_n_im_reg[NW-1];
            f5_d_reg     <= f4_d_reg;
            f5_q_reg     <= f4_q_reg;
        end
    end

    // f6: divide by three through the reciprocal
    pdq_pkg::op_t        f6_op_reg;
    logic [AW-1:0]       f6_ang_reg;
    logic [P6W-1:0]      f6_p_re_reg, f6_p_im_reg;
    logic                f6_nn_re_reg, f6_nn_im_reg;
    logic signed [D-1:0] f6_d_reg, f6_q_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f6_op_reg    <= f5_op_reg;
            f6_ang_reg   <= f5_ang_reg;
            f6_p_re_reg  <= P6W'(f5_w_re_reg) * P6W'(pdq_pkg::DIV3_MUL);
            f6_p_im_reg  <= P6W'(f5_w_im_reg) * P6W'(pdq_pkg::DIV3_MUL);
            f6_nn_re_reg <= f5_nn_re_reg;
            f6_nn_im_reg <= f5_nn_im_reg;
            f6_d_reg     <= f5_d_reg;
            f6_q_reg     <= f5_q_reg;
        end
    end

    // f7: signed quotient, or d and q when going to abc
    logic [P6W-1:0]       f6_qt_re, f6_qt_im;
    logic signed [XW-1:0] f6_pre, f6_pim;

    assign f6_qt_re = f6_p_re_reg >> pdq_pkg::DIV3_SHIFT;
    assign f6_qt_im = f6_p_im_reg >> pdq_pkg::DIV3_SHIFT;
    assign f6_pre   = f6_nn_re_reg ? -$signed({1'b0, f6_qt_re[D:0]})
                                   : $signed({1'b0, f6_qt_re[D:0]});
    assign f6_pim   = f6_nn_im_reg ? -$signed({1'b0, f6_qt_im[D:0]})
                                   : $signed({1'b0, f6_qt_im[D:0]});

    pdq_pkg::op_t         f7_op_reg;
    logic [AW-1:0]        f7_ang_reg;
    logic signed [XW-1:0] f7_x_reg, f7_y_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f7_op_reg  <= f6_op_reg;
            f7_ang_reg <= f6_ang_reg;
            if (f6_op_reg == pdq_pkg::OP_DQ_TO_ABC)
            begin
                f7_x_reg <= XW'(f6_d_reg);
                f7_y_reg <= XW'(f6_q_reg);
            end
            else
            begin
                f7_x_reg <= f6_pre;
                f7_y_reg <= f6_pim;
            end
        end
    end

    // cordic stages
    logic signed [CW-1:0] cx_reg [N];
    logic signed [CW-1:0] cy_reg [N];
    logic signed [ZW-1:0] cz_reg [N];
    pdq_pkg::op_t         cop_reg [N];
    logic [1:0]           cquad_reg [N];
    logic signed [XW-1:0] cxd_reg [N];
    logic signed [XW-1:0] cyd_reg [N];

    logic signed [CW-1:0] cx_in [N];
    logic signed [CW-1:0] cy_in [N];
    logic signed [ZW-1:0] cz_in [N];
    pdq_pkg::op_t         cop_in [N];
    logic [1:0]           cquad_in [N];
    logic signed [XW-1:0] cxd_in [N];
    logic signed [XW-1:0] cyd_in [N];

    always_comb
    begin
        for (int i = 0; i < N; i++)
        begin
            if (i == 0)
            begin
                cx_in[i]    = $signed(pdq_pkg::INV_GAIN_Q30);
                cy_in[i]    = '0;
                cz_in[i]    = $signed({2'b00, f7_ang_reg[AW-3:0], {(32 - AW){1'b0}}});
                cop_in[i]   = f7_op_reg;
                cquad_in[i] = f7_ang_reg[AW-1:AW-2];
                cxd_in[i]   = f7_x_reg;
                cyd_in[i]   = f7_y_reg;
            end
            else
            begin
                cx_in[i]    = cx_reg[i-1];
                cy_in[i]    = cy_reg[i-1];
                cz_in[i]    = cz_reg[i-1];
                cop_in[i]   = cop_reg[i-1];
                cquad_in[i] = cquad_reg[i-1];
                cxd_in[i]   = cxd_reg[i-1];
                cyd_in[i]   = cyd_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < N; i++)
            begin
                if (!cz_in[i][ZW-1])
                begin
                    cx_reg[i] <= cx_in[i] - (cy_in[i] >>> i);
                    cy_reg[i] <= cy_in[i] + (cx_in[i] >>> i);
                    cz_reg[i] <= cz_in[i] - $signed(ZW'(pdq_pkg::atan_turn(5'(i))));
                end
                else
                begin
                    cx_reg[i] <= cx_in[i] + (cy_in[i] >>> i);
                    cy_reg[i] <= cy_in[i] - (cx_in[i] >>> i);
                    cz_reg[i] <= cz_in[i] + $signed(ZW'(pdq_pkg::atan_turn(5'(i))));
                end
                cop_reg[i]   <= cop_in[i];
                cquad_reg[i] <= cquad_in[i];
                cxd_reg[i]   <= cxd_in[i];
                cyd_reg[i]   <= cyd_in[i];
            end
        end
    end

    // r1: quadrant folded into magnitudes and signs
    logic signed [CW-1:0] kx, ky;
    logic [CW-1:0]        kx_m, ky_m;
    logic                 kx_neg, kx_pos, ky_neg, ky_pos;
    logic [CW-1:0]        cm_sel, sm_sel;
    logic                 cn_sel, sn_sel;
    logic signed [XW-1:0] kxd, kyd;

    assign kx     = cx_reg[N-1];
    assign ky     = cy_reg[N-1];
    assign kx_m   = kx[CW-1] ? CW'(-kx) : CW'(kx);
    assign ky_m   = ky[CW-1] ? CW'(-ky) : CW'(ky);
    assign kx_neg = kx[CW-1];
    assign ky_neg = ky[CW-1];
    assign kx_pos = !kx[CW-1] && (kx != '0);
    assign ky_pos = !ky[CW-1] && (ky != '0);
    assign kxd    = cxd_reg[N-1];
    assign kyd    = cyd_reg[N-1];

    always_comb
    begin
        case (cquad_reg[N-1])
            2'd0:
            begin
                cm_sel = kx_m; cn_sel = kx_neg; sm_sel = ky_m; sn_sel = ky_neg;
            end
            2'd1:
            begin
                cm_sel = ky_m; cn_sel = ky_pos; sm_sel = kx_m; sn_sel = kx_neg;
            end
            2'd2:
            begin
                cm_sel = kx_m; cn_sel = kx_pos; sm_sel = ky_m; sn_sel = ky_pos;
            end
            2'd3:
            begin
                cm_sel = ky_m; cn_sel = ky_neg; sm_sel = kx_m; sn_sel = kx_pos;
            end
            default:
            begin
                cm_sel = kx_m; cn_sel = kx_neg; sm_sel = ky_m; sn_sel = ky_neg;
            end
        endcase
    end

    pdq_pkg::op_t  r1_op_reg;
    logic [CW-1:0] r1_cm_reg, r1_sm_reg;
    logic          r1_cn_reg, r1_sn_reg;
    logic [XW-1:0] r1_xm_reg, r1_ym_reg;
    logic          r1_xn_reg, r1_yn_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r1_op_reg <= cop_reg[N-1];
            r1_cm_reg <= cm_sel;
            r1_sm_reg <= sm_sel;
            r1_cn_reg <= cn_sel;
            r1_sn_reg <= sn_sel;
            r1_xm_reg <= kxd[XW-1] ? XW'(-kxd) : XW'(kxd);
            r1_ym_reg <= kyd[XW-1] ? XW'(-kyd) : XW'(kyd);
            r1_xn_reg <= kxd[XW-1];
            r1_yn_reg <= kyd[XW-1];
        end
    end

    // r2: rotation products x*c, y*s, y*c, x*s
    pdq_pkg::op_t   r2_op_reg;
    logic [RPW-1:0] r2_p1_reg, r2_p2_reg, r2_p3_reg, r2_p4_reg;
    logic           r2_n1_reg, r2_n2_reg, r2_n3_reg, r2_n4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r2_op_reg <= r1_op_reg;
            r2_p1_reg <= RPW'(r1_xm_reg) * RPW'(r1_cm_reg);
            r2_p2_reg <= RPW'(r1_ym_reg) * RPW'(r1_sm_reg);
            r2_p3_reg <= RPW'(r1_ym_reg) * RPW'(r1_cm_reg);
            r2_p4_reg <= RPW'(r1_xm_reg) * RPW'(r1_sm_reg);
            r2_n1_reg <= r1_xn_reg ^ r1_cn_reg;
            r2_n2_reg <= r1_yn_reg ^ r1_sn_reg;
            r2_n3_reg <= r1_yn_reg ^ r1_cn_reg;
            r2_n4_reg <= r1_xn_reg ^ r1_sn_reg;
        end
    end

    // r3: round the products
    pdq_pkg::op_t        r3_op_reg;
    logic signed [PW-1:0] r3_p1_reg, r3_p2_reg, r3_p3_reg, r3_p4_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r3_op_reg <= r2_op_reg;
            r3_p1_reg <= PW'(pdq_pkg::rnd_q30(64'(r2_p1_reg), r2_n1_reg));
            r3_p2_reg <= PW'(pdq_pkg::rnd_q30(64'(r2_p2_reg), r2_n2_reg));
            r3_p3_reg <= PW'(pdq_pkg::rnd_q30(64'(r2_p3_reg), r2_n3_reg));
            r3_p4_reg <= PW'(pdq_pkg::rnd_q30(64'(r2_p4_reg), r2_n4_reg));
        end
    end

    // r4: d, q or phase a
    pdq_pkg::op_t         r4_op_reg;
    logic signed [EW-1:0] r4_e1_reg, r4_e2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r4_op_reg <= r3_op_reg;
            if (r3_op_reg == pdq_pkg::OP_DQ_TO_ABC)
            begin
                r4_e1_reg <= EW'(r3_p1_reg) - EW'(r3_p2_reg);
                r4_e2_reg <= EW'(r3_p3_reg) + EW'(r3_p4_reg);
            end
            else
            begin
                r4_e1_reg <= EW'(r3_p1_reg) + EW'(r3_p2_reg);
                r4_e2_reg <= EW'(r3_p3_reg) - EW'(r3_p4_reg);
            end
        end
    end

    // r5: magnitudes of phase a
    pdq_pkg::op_t         r5_op_reg;
    logic signed [EW-1:0] r5_e1_reg, r5_e2_reg;
    logic [EW-1:0]        r5_m1_reg, r5_m2_reg;
    logic                 r5_n1_reg, r5_n2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r5_op_reg <= r4_op_reg;
            r5_e1_reg <= r4_e1_reg;
            r5_e2_reg <= r4_e2_reg;
            r5_m1_reg <= r4_e1_reg[EW-1] ? EW'(-r4_e1_reg) : EW'(r4_e1_reg);
            r5_m2_reg <= r4_e2_reg[EW-1] ? EW'(-r4_e2_reg) : EW'(r4_e2_reg);
            r5_n1_reg <= r4_e1_reg[EW-1];
            r5_n2_reg <= r4_e2_reg[EW-1];
        end
    end

    // r6: sqrt3 times phase a
    pdq_pkg::op_t         r6_op_reg;
    logic signed [EW-1:0] r6_e1_reg, r6_e2_reg;
    logic [E6W-1:0]       r6_p1_reg, r6_p2_reg;
    logic                 r6_n1_reg, r6_n2_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r6_op_reg <= r5_op_reg;
            r6_e1_reg <= r5_e1_reg;
            r6_e2_reg <= r5_e2_reg;
            r6_p1_reg <= E6W'(r5_m1_reg) * E6W'(pdq_pkg::SQRT3_Q30);
            r6_p2_reg <= E6W'(r5_m2_reg) * E6W'(pdq_pkg::SQRT3_Q30);
            r6_n1_reg <= r5_n1_reg;
            r6_n2_reg <= r5_n2_reg;
        end
    end

    // r7: rounded sqrt3 terms
    pdq_pkg::op_t         r7_op_reg;
    logic signed [EW-1:0] r7_e1_reg, r7_e2_reg;
    logic signed [RW-1:0] r7_r3re_reg, r7_r3im_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r7_op_reg   <= r6_op_reg;
            r7_e1_reg   <= r6_e1_reg;
            r7_e2_reg   <= r6_e2_reg;
            r7_r3re_reg <= RW'(pdq_pkg::rnd_q30(64'(r6_p1_reg), r6_n1_reg));
            r7_r3im_reg <= RW'(pdq_pkg::rnd_q30(64'(r6_p2_reg), r6_n2_reg));
        end
    end

    // r8: twice phases b and c
    pdq_pkg::op_t         r8_op_reg;
    logic signed [EW-1:0] r8_e1_reg, r8_e2_reg;
    logic signed [SW-1:0] r8_bre_reg, r8_bim_reg, r8_cre_reg, r8_cim_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r8_op_reg  <= r7_op_reg;
            r8_e1_reg  <= r7_e1_reg;
            r8_e2_reg  <= r7_e2_reg;
            r8_bre_reg <= SW'(r7_r3im_reg) - SW'(r7_e1_reg);
            r8_bim_reg <= -SW'(r7_e2_reg) - SW'(r7_r3re_reg);
            r8_cre_reg <= -SW'(r7_e1_reg) - SW'(r7_r3im_reg);
            r8_cim_reg <= SW'(r7_r3re_reg) - SW'(r7_e2_reg);
        end
    end

    // r9: halve with rounding away from zero, saturate, pack
    logic signed [SW-1:0] h_bre, h_bim, h_cre, h_cim;
    logic [D-1:0]         s_e1, s_e2;
    logic [8*D-1:0]       r9_next;

    assign h_bre = r8_bre_reg[SW-1] ? (r8_bre_reg >>> 1) : ((r8_bre_reg + SW'(1)) >>> 1);
    assign h_bim = r8_bim_reg[SW-1] ? (r8_bim_reg >>> 1) : ((r8_bim_reg + SW'(1)) >>> 1);
    assign h_cre = r8_cre_reg[SW-1] ? (r8_cre_reg >>> 1) : ((r8_cre_reg + SW'(1)) >>> 1);
    assign h_cim = r8_cim_reg[SW-1] ? (r8_cim_reg >>> 1) : ((r8_cim_reg + SW'(1)) >>> 1);
    assign s_e1  = pdq_pkg::sat_data(64'(r8_e1_reg));
    assign s_e2  = pdq_pkg::sat_data(64'(r8_e2_reg));

    always_comb
    begin
        if (r8_op_reg == pdq_pkg::OP_DQ_TO_ABC)
        begin
            r9_next = {pdq_pkg::sat_data(64'(h_cim)), pdq_pkg::sat_data(64'(h_cre)),
                       pdq_pkg::sat_data(64'(h_bim)), pdq_pkg::sat_data(64'(h_bre)),
                       s_e2, s_e1, {(2*D){1'b0}}};
        end
        else
        begin
            r9_next = {{(6*D){1'b0}}, s_e2, s_e1};
        end
    end

    logic [8*D-1:0] r9_data_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r9_data_reg <= r9_next;
        end
    end

    // output register with skid entry
    logic out_free;
    logic x_valid;

    assign out_free = !out_valid_reg || m_tready;
    assign x_valid  = vld_reg[NS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= x_valid;
            end
        end
        else if (x_valid && en)
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : r9_data_reg;
        end
        if (!out_free && en)
        begin
            skid_data_reg <= r9_data_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held without a waiting result");

    a_skid_fill_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_tready))
        else $error("skid entry filled without an output stall");

    a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !m_tready) |=> (skid_valid_reg && $stable(skid_data_reg)))
        else $error("skid entry lost while output stalled");
`endif

endmodule
